[hw/rtl/velocity_drag_damping_top_defines.svh]
// ----------------------------------------------------------------------------
// Velocity drag damping assertion macros
// Shared concurrent assertion forms used by the damping datapath.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_DRAG_DAMPING_TOP_DEFINES_SVH
`define VELOCITY_DRAG_DAMPING_TOP_DEFINES_SVH

// Same-cycle implication.
`define VDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("velocity drag damping assertion failed");

// Next-cycle implication.
`define VDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("velocity drag damping assertion failed");

`endif

[hw/rtl/vdd_pkg.sv]
// ----------------------------------------------------------------------------
// Velocity drag damping package
// Register indexes and fixed constants of the drag datapath.
// ----------------------------------------------------------------------------
package vdd_pkg;

   localparam int STEP_BITS = 32;
   localparam int CAP_LOG   = 60;
   localparam int PROD_W    = CAP_LOG + 1;
   localparam int REG_IDX_W = 3;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_WIND_X         = 3'd0;
   localparam reg_idx_type REG_WIND_Y         = 3'd1;
   localparam reg_idx_type REG_WIND_Z         = 3'd2;
   localparam reg_idx_type REG_MEDIUM_DENSITY = 3'd3;
   localparam reg_idx_type REG_LINEAR_COEF    = 3'd4;
   localparam reg_idx_type REG_ANGULAR_COEF   = 3'd5;
   localparam reg_idx_type REG_STEP_SIZE      = 3'd6;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd42949673;

endpackage

[hw/rtl/vdd_req_if.sv]
// ----------------------------------------------------------------------------
// Velocity drag damping request channel
// Carries one velocity vector and its drag kind per transaction.
// ----------------------------------------------------------------------------
interface vdd_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic                         drag_kind;
   logic signed [DATA_WIDTH-1:0] in_x;
   logic signed [DATA_WIDTH-1:0] in_y;
   logic signed [DATA_WIDTH-1:0] in_z;

   modport source (output valid, drag_kind, in_x, in_y, in_z, input ready);
   modport sink   (input valid, drag_kind, in_x, in_y, in_z, output ready);
endinterface

[hw/rtl/vdd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Velocity drag damping response channel
// Carries one damped velocity vector and the stop flag per transaction.
// ----------------------------------------------------------------------------
interface vdd_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_x;
   logic signed [DATA_WIDTH-1:0] out_y;
   logic signed [DATA_WIDTH-1:0] out_z;
   logic                         fully_stopped;

   modport source (output valid, out_x, out_y, out_z, fully_stopped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, fully_stopped, output ready);
endinterface

[hw/rtl/vdd_csr_if.sv]
// ----------------------------------------------------------------------------
// Velocity drag damping register write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface vdd_csr_if #(
   parameter int DATA_WIDTH = 32
);
   import vdd_pkg::*;

   localparam int CSR_W = (DATA_WIDTH > STEP_BITS) ? DATA_WIDTH : STEP_BITS;

   logic              valid;
   logic              ready;
   reg_idx_type       reg_index;
   logic [CSR_W-1:0]  data;

   modport source (output valid, reg_index, data, input ready);
   modport sink   (input valid, reg_index, data, output ready);
endinterface

[hw/rtl/velocity_drag_damping_top.sv]
// ----------------------------------------------------------------------------
// Velocity drag damping top level
// Three front stages, one square-root stage per root bit, then eight
// product stages. Throughput is one transaction per cycle while the
// output is not stalled; the square-root bit stages set the depth.
// Synchronous active-high reset empties the pipeline and loads the
// register defaults (density 1.0, step about 0.01, all else zero).
// ----------------------------------------------------------------------------
`include "velocity_drag_damping_top_defines.svh"

module velocity_drag_damping_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic    clock,
   input logic    reset,
   vdd_req_if.sink   req_chan,
   vdd_rsp_if.source rsp_chan,
   vdd_csr_if.sink   csr_chan
);
   import vdd_pkg::*;

   // Datapath widths. The difference of velocity and wind needs one extra
   // bit; its magnitude fits in the same count as an unsigned value.
   localparam int DW   = DATA_WIDTH;
   localparam int MW   = DW + 1;
   localparam int SQW  = 2 * MW;
   localparam int RW   = MW + 1;
   localparam int SW   = 2 * RW;
   localparam int PW   = PROD_W;
   localparam int HIW  = PW - STEP_BITS;
   localparam int XW   = PW + ((DW > STEP_BITS) ? DW : STEP_BITS) + 1;
   localparam int RMW  = STEP_BITS + 1;
   localparam int SPW  = MW + RMW;
   localparam int VW   = MW + 3;

   localparam logic [PW-1:0] CAP_Q = PW'(1) << CAP_LOG;
   localparam logic [PW-1:0] ONE_Q = PW'(1) << (FRAC_BITS + STEP_BITS);
   localparam logic signed [VW-1:0] SAT_HI = VW'((64'(1) << (DW - 1)) - 64'(1));
   localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

   function automatic logic [PW-1:0] cap_sat(input logic [XW-1:0] v);
      logic [PW-1:0] r;
      r = (v > XW'(CAP_Q)) ? CAP_Q : v[PW-1:0];
      return r;
   endfunction

   function automatic logic [MW-1:0] mag_of(input logic signed [DW:0] v);
      logic [MW-1:0] r;
      r = v[DW] ? MW'(-v) : MW'(v);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Config registers. Writes are always taken; unknown indexes are dropped.
   // Software must write only while the pipeline is drained (not enforced).
   // -------------------------------------------------------------------------
   logic signed [DW-1:0]  wind_ff [3];
   logic [DW-1:0]         density_ff;
   logic [DW-1:0]         lin_coef_ff;
   logic [DW-1:0]         ang_coef_ff;
   logic [STEP_BITS-1:0]  step_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wind_ff[0]  <= '0;
         wind_ff[1]  <= '0;
         wind_ff[2]  <= '0;
         density_ff  <= DW'(1) << FRAC_BITS;
         lin_coef_ff <= '0;
         ang_coef_ff <= '0;
         step_ff     <= STEP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            REG_WIND_X:         wind_ff[0]  <= csr_chan.data[DW-1:0];
            REG_WIND_Y:         wind_ff[1]  <= csr_chan.data[DW-1:0];
            REG_WIND_Z:         wind_ff[2]  <= csr_chan.data[DW-1:0];
            REG_MEDIUM_DENSITY: density_ff  <= csr_chan.data[DW-1:0];
            REG_LINEAR_COEF:    lin_coef_ff <= csr_chan.data[DW-1:0];
            REG_ANGULAR_COEF:   ang_coef_ff <= csr_chan.data[DW-1:0];
            REG_STEP_SIZE:      step_ff     <= csr_chan.data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control. Every stage has a valid bit and loads whenever it
   // is empty or its successor loads, so bubbles collapse and a stalled
   // output holds every stage behind it without loss.
   // -------------------------------------------------------------------------
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff;
   logic g_v_ff, h_v_ff, i_v_ff, j_v_ff, k_v_ff;
   logic sq_v_ff [RW];
   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h, en_i, en_j, en_k;
   logic sq_en [RW];

   always_comb begin
      en_k = !k_v_ff || rsp_chan.ready;
      en_j = !j_v_ff || en_k;
      en_i = !i_v_ff || en_j;
      en_h = !h_v_ff || en_i;
      en_g = !g_v_ff || en_h;
      en_f = !f_v_ff || en_g;
      en_e = !e_v_ff || en_f;
      en_d = !d_v_ff || en_e;
      sq_en[RW-1] = !sq_v_ff[RW-1] || en_d;
      for (int k = RW - 2; k >= 0; k--) begin
         sq_en[k] = !sq_v_ff[k] || sq_en[k+1];
      end
      en_c = !c_v_ff || sq_en[0];
      en_b = !b_v_ff || en_c;
      en_a = !a_v_ff || en_b;
   end

   assign req_chan.ready = en_a;

   // -------------------------------------------------------------------------
   // Stage A: remove the wind for linear drag.
   // -------------------------------------------------------------------------
   logic signed [DW:0] a_d_ff [3];
   logic               a_kind_ff;
   logic signed [DW-1:0] in_vec [3];

   assign in_vec[0] = req_chan.in_x;
   assign in_vec[1] = req_chan.in_y;
   assign in_vec[2] = req_chan.in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en_a) begin
         a_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_kind_ff <= req_chan.drag_kind;
         for (int i = 0; i < 3; i++) begin
            a_d_ff[i] <= (DW+1)'(in_vec[i]) -
                         (req_chan.drag_kind ? '0 : (DW+1)'(wind_ff[i]));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage B: square each magnitude. Stage C: sum the squares.
   // -------------------------------------------------------------------------
   logic signed [DW:0] b_d_ff [3];
   logic               b_kind_ff;
   logic [SQW-1:0]     b_sq_ff [3];
   logic signed [DW:0] c_d_ff [3];
   logic               c_kind_ff;
   logic [SW-1:0]      c_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_kind_ff <= a_kind_ff;
         for (int i = 0; i < 3; i++) begin
            b_d_ff[i]  <= a_d_ff[i];
            b_sq_ff[i] <= SQW'(mag_of(a_d_ff[i])) * SQW'(mag_of(a_d_ff[i]));
         end
      end
      if (en_c) begin
         c_kind_ff <= b_kind_ff;
         c_d_ff    <= b_d_ff;
         c_sum_ff  <= SW'(b_sq_ff[0]) + SW'(b_sq_ff[1]) + SW'(b_sq_ff[2]);
      end
   end

   // -------------------------------------------------------------------------
   // Square root, one root bit per stage, restoring form. The remainder
   // starts as the sum; each stage tries the next bit down.
   // -------------------------------------------------------------------------
   logic [SW-1:0]      sq_rem_ff  [RW];
   logic [RW-1:0]      sq_root_ff [RW];
   logic signed [DW:0] sq_d_ff    [RW][3];
   logic               sq_kind_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int B = RW - 1 - k;
      logic [SW-1:0]      prev_rem;
      logic [RW-1:0]      prev_root;
      logic               prev_v;
      logic               prev_kind;
      logic signed [DW:0] prev_d [3];
      logic [SW:0]        trial;
      logic               take;

      if (k == 0) begin : g_first
         assign prev_rem  = c_sum_ff;
         assign prev_root = '0;
         assign prev_v    = c_v_ff;
         assign prev_kind = c_kind_ff;
         assign prev_d    = c_d_ff;
      end else begin : g_next
         assign prev_rem  = sq_rem_ff[k-1];
         assign prev_root = sq_root_ff[k-1];
         assign prev_v    = sq_v_ff[k-1];
         assign prev_kind = sq_kind_ff[k-1];
         assign prev_d    = sq_d_ff[k-1];
      end

      assign trial = ((SW+1)'(prev_root) << (B + 1)) | ((SW+1)'(1) << (2 * B));
      assign take  = {1'b0, prev_rem} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (sq_en[k]) begin
            sq_v_ff[k] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (sq_en[k]) begin
            sq_kind_ff[k] <= prev_kind;
            sq_d_ff[k]    <= prev_d;
            sq_rem_ff[k]  <= take ? (prev_rem - trial[SW-1:0]) : prev_rem;
            sq_root_ff[k] <= take ? (prev_root | (RW'(1) << B)) : prev_root;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stages D to I: the drag product length * density * coef * step, each
   // step truncated and capped. Wide multiplies are split at 32 bits into
   // two partial products and joined in the following stage.
   // -------------------------------------------------------------------------
   logic signed [DW:0]     d_d_ff [3], e_d_ff [3], f_d_ff [3], g_d_ff [3];
   logic signed [DW:0]     h_d_ff [3], i_d_ff [3], j_d_ff [3];
   logic                   d_kind_ff, e_kind_ff, f_kind_ff, g_kind_ff;
   logic                   h_kind_ff, i_kind_ff, j_kind_ff;
   logic [RW+DW-1:0]       d_m_ff;
   logic [PW-1:0]          e_p1_ff;
   logic [STEP_BITS+DW-1:0] f_lo_ff;
   logic [HIW+DW-1:0]      f_hi_ff;
   logic [PW-1:0]          g_p2_ff;
   logic [2*STEP_BITS-1:0] h_lo_ff;
   logic [HIW+STEP_BITS-1:0] h_hi_ff;
   logic [RMW-1:0]         i_remain_ff;
   logic                   i_stop_ff, j_stop_ff;
   logic [SPW-1:0]         j_prod_ff [3];

   logic [DW-1:0]  f_coef;
   logic [XW-1:0]  g_full;
   logic [XW-1:0]  i_full;
   logic [PW-1:0]  i_p3;

   assign f_coef = e_kind_ff ? ang_coef_ff : lin_coef_ff;
   assign g_full = (XW'(f_hi_ff) << STEP_BITS) + XW'(f_lo_ff);
   assign i_full = (XW'(h_hi_ff) << STEP_BITS) + XW'(h_lo_ff);
   assign i_p3   = cap_sat(i_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
      end else begin
         if (en_d) d_v_ff <= sq_v_ff[RW-1];
         if (en_e) e_v_ff <= d_v_ff;
         if (en_f) f_v_ff <= e_v_ff;
         if (en_g) g_v_ff <= f_v_ff;
         if (en_h) h_v_ff <= g_v_ff;
         if (en_i) i_v_ff <= h_v_ff;
         if (en_j) j_v_ff <= i_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_kind_ff <= sq_kind_ff[RW-1];
         d_d_ff    <= sq_d_ff[RW-1];
         d_m_ff    <= (RW+DW)'(sq_root_ff[RW-1]) * (RW+DW)'(density_ff);
      end
      if (en_e) begin
         e_kind_ff <= d_kind_ff;
         e_d_ff    <= d_d_ff;
         e_p1_ff   <= cap_sat(XW'(d_m_ff >> FRAC_BITS));
      end
      if (en_f) begin
         f_kind_ff <= e_kind_ff;
         f_d_ff    <= e_d_ff;
         f_lo_ff   <= (STEP_BITS+DW)'(e_p1_ff[STEP_BITS-1:0]) * (STEP_BITS+DW)'(f_coef);
         f_hi_ff   <= (HIW+DW)'(e_p1_ff[PW-1:STEP_BITS]) * (HIW+DW)'(f_coef);
      end
      if (en_g) begin
         g_kind_ff <= f_kind_ff;
         g_d_ff    <= f_d_ff;
         g_p2_ff   <= cap_sat(g_full >> FRAC_BITS);
      end
      if (en_h) begin
         h_kind_ff <= g_kind_ff;
         h_d_ff    <= g_d_ff;
         h_lo_ff   <= (2*STEP_BITS)'(g_p2_ff[STEP_BITS-1:0]) * (2*STEP_BITS)'(step_ff);
         h_hi_ff   <= (HIW+STEP_BITS)'(g_p2_ff[PW-1:STEP_BITS]) *
                      (HIW+STEP_BITS)'(step_ff);
      end
      if (en_i) begin
         // A product above one clamps the remaining factor to zero; a product
         // of exactly one gives zero too but is not reported as stopped.
         i_kind_ff   <= h_kind_ff;
         i_d_ff      <= h_d_ff;
         i_stop_ff   <= i_p3 > ONE_Q;
         i_remain_ff <= (i_p3 > ONE_Q) ? '0 : RMW'((ONE_Q - i_p3) >> FRAC_BITS);
      end
      if (en_j) begin
         j_kind_ff <= i_kind_ff;
         j_d_ff    <= i_d_ff;
         j_stop_ff <= i_stop_ff;
         for (int i = 0; i < 3; i++) begin
            j_prod_ff[i] <= SPW'(mag_of(i_d_ff[i])) * SPW'(i_remain_ff);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage K (output register): truncate the scaled magnitude, restore the
   // sign, add the wind back for linear drag and saturate.
   // -------------------------------------------------------------------------
   logic signed [DW-1:0] k_out_ff [3];
   logic                 k_stop_ff;
   logic signed [VW-1:0] k_val [3];
   logic [MW:0]          k_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_mag[i] = (MW+1)'(j_prod_ff[i] >> STEP_BITS);
         k_val[i] = (j_d_ff[i][DW] ? -VW'(k_mag[i]) : VW'(k_mag[i])) +
                    (j_kind_ff ? '0 : VW'(wind_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else if (en_k) begin
         k_v_ff <= j_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_k) begin
         k_stop_ff <= j_stop_ff;
         for (int i = 0; i < 3; i++) begin
            if (k_val[i] > SAT_HI) begin
               k_out_ff[i] <= SAT_HI[DW-1:0];
            end else if (k_val[i] < SAT_LO) begin
               k_out_ff[i] <= SAT_LO[DW-1:0];
            end else begin
               k_out_ff[i] <= k_val[i][DW-1:0];
            end
         end
      end
   end

   assign rsp_chan.valid         = k_v_ff;
   assign rsp_chan.out_x         = k_out_ff[0];
   assign rsp_chan.out_y         = k_out_ff[1];
   assign rsp_chan.out_z         = k_out_ff[2];
   assign rsp_chan.fully_stopped = k_stop_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   `VDD_ASSERT_IMPL(a_ready_when_empty, clock, reset, !a_v_ff, req_chan.ready)
   `VDD_ASSERT_NEXT(a_root_out_held, clock, reset, d_v_ff && !en_e, d_v_ff)
   `VDD_ASSERT_IMPL(a_remain_range, clock, reset, i_v_ff,
                    i_remain_ff <= (RMW'(1) << STEP_BITS))
   `VDD_ASSERT_IMPL(a_stop_zero, clock, reset, i_v_ff && i_stop_ff, i_remain_ff == '0)

endmodule
